// ===== src/osp_pkg.sv =====
// Shared types, constants and the opcode length table for the opcode stream profiler.
// Has no dependencies. Every other source file imports it.
package osp_pkg;

	// Capacity and sizing constants.
	localparam int MAX_CODE_BYTES = 65536;
	localparam int COUNT_LIMIT    = 65536;
	localparam int COUNT_CAP_INT  = (MAX_CODE_BYTES < COUNT_LIMIT) ? MAX_CODE_BYTES : COUNT_LIMIT;

	localparam int OPCODE_W   = 8;
	localparam int TOTAL_W    = 17;
	localparam int DISTINCT_W = 9;
	localparam int EXTRA_W    = 2;
	localparam int OUT_DATA_W = 32;
	localparam int OPCODE_NUM = 256;

	localparam logic [TOTAL_W-1:0] COUNT_CAP = TOTAL_W'(COUNT_CAP_INT);

	// Event queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Number of operand bytes that follow each opcode (instruction length less one).
	localparam logic [EXTRA_W-1:0] OPERAND_BYTES [0:OPCODE_NUM-1] = '{
		0,1,2,0,0,1,0,0, 0,0,0,0,0,0,0,0,
		2,1,2,0,0,1,0,0, 0,0,0,0,0,0,0,0,
		2,1,0,0,1,1,0,0, 0,0,0,0,0,0,0,0,
		2,1,0,0,1,1,0,0, 0,0,0,0,0,0,0,0,
		1,1,1,2,1,1,0,0, 0,0,0,0,0,0,0,0,
		1,1,1,2,1,1,0,0, 0,0,0,0,0,0,0,0,
		1,1,1,2,1,1,0,0, 0,0,0,0,0,0,0,0,
		1,1,1,0,1,2,1,1, 1,1,1,1,1,1,1,1,
		1,1,1,0,0,2,1,1, 1,1,1,1,1,1,1,1,
		2,1,1,0,1,1,0,0, 0,0,0,0,0,0,0,0,
		1,1,1,0,0,0,1,1, 1,1,1,1,1,1,1,1,
		1,1,1,0,2,2,2,2, 2,2,2,2,2,2,2,2,
		1,1,1,0,0,1,0,0, 0,0,0,0,0,0,0,0,
		1,1,1,0,0,2,0,0, 1,1,1,1,1,1,1,1,
		0,1,0,0,0,1,0,0, 0,0,0,0,0,0,0,0,
		0,1,0,0,0,1,0,0, 0,0,0,0,0,0,0,0
	};

	// One classified byte: an instruction start, the end of the buffer, or both.
	typedef struct packed {
		logic                start;
		logic [OPCODE_W-1:0] opcode;
		logic                last;
	} osp_event_t;

	// An event slot together with its qualifier, as passed through the queue.
	typedef struct packed {
		logic       valid;
		osp_event_t ev;
	} osp_slot_t;

endpackage

// ===== src/opcode_stream_profiler_top.sv =====
// Top level of the opcode stream profiler: front classifier, event queue and back counters.
// Depends on osp_pkg, osp_front, osp_queue and osp_back.

// The block takes one 8051 program byte per transfer on the s_ side and sustains one byte per
// clock cycle while the event queue has room. The front part decodes each opcode's length and
// skips its operand bytes; only instruction starts and the final byte of a buffer (s_tlast)
// enter a four-entry event queue. The back part drains one event per cycle, but a buffer end
// waits while the output holds an untaken result; it counts instructions (saturating at 65536)
// and marks opcodes in a 256-bit map held in flip-flops, so no clearing pass is ever needed.
// A buffer's result passes through the event queue, behind any earlier events, into an output
// register that leaves both counts in place until taken; a held result stalls only the next
// buffer end, while the bytes of the following buffer keep flowing until the queue fills.
module opcode_stream_profiler_top
	import osp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [OPCODE_W-1:0]   s_tdata,  // code_byte [7:0]
	input  logic                  s_tlast,  // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // instruction_total [16:0], distinct_opcodes [25:17]
);

	osp_slot_t push;
	osp_slot_t head;
	logic      queue_full;
	logic      pop;

	// Byte classification.
	osp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.queue_full (queue_full),
		.push       (push)
	);

	// Decoupling queue.
	osp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	// Counting and result output.
	osp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== src/osp_front.sv =====
// Front part: accepts code bytes, tracks operand bytes still to skip and classifies each byte.
// Depends on osp_pkg. Feeds osp_queue.
module osp_front
	import osp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [OPCODE_W-1:0] s_tdata,  // code_byte [7:0]
	input  logic                s_tlast,  // last_byte
	input  logic                queue_full,
	output osp_slot_t           push
);

	logic               accept;
	logic               is_start;
	logic [EXTRA_W-1:0] operand_left_q;

	// A byte is taken whenever the queue has room for its event.
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && !queue_full;
	assign is_start = (operand_left_q == '0);

	// Only instruction starts and buffer ends are of interest to the back part.
	always_comb begin
		push.valid     = accept && (is_start || s_tlast);
		push.ev.start  = is_start;
		push.ev.opcode = s_tdata;
		push.ev.last   = s_tlast;
	end

	// Operand skip counter; the end of a buffer drops any operands still owed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_left_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				operand_left_q <= '0;
			end else if (is_start) begin
				operand_left_q <= OPERAND_BYTES[s_tdata];
			end else begin
				operand_left_q <= operand_left_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/osp_queue.sv =====
// Short first-in first-out queue of classified events between the front and back parts.
// Depends on osp_pkg.
module osp_queue
	import osp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  osp_slot_t push,
	output logic      full,
	output osp_slot_t head,
	input  logic      pop
);

	osp_event_t             slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.ev    = slots_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	// Event storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.ev;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/osp_back.sv =====
// Back part: counts instruction starts, keeps the opcode-seen map and forms the result transfer.
// Depends on osp_pkg. Drains osp_queue.
module osp_back
	import osp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  osp_slot_t             head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata  // instruction_total [16:0], distinct_opcodes [25:17]
);

	logic [TOTAL_W-1:0]    started_q;
	logic [DISTINCT_W-1:0] unique_q;
	logic [OPCODE_NUM-1:0] seen_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] result_q;

	logic                  out_free;
	logic                  new_opcode;
	logic [TOTAL_W-1:0]    started_next;
	logic [DISTINCT_W-1:0] unique_next;

	// A buffer end waits for the output register; other events drain at once.
	assign out_free = !out_valid_q || m_tready;
	assign pop      = head.valid && (!head.ev.last || out_free);

	// Counter updates for the event at the head of the queue.
	always_comb begin
		new_opcode   = head.ev.start && !seen_q[head.ev.opcode];
		started_next = started_q;
		if (head.ev.start && (started_q < COUNT_CAP)) begin
			started_next = started_q + 1'b1;
		end
		unique_next = unique_q + DISTINCT_W'(new_opcode);
	end

	// Profile state, cleared after each buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
			unique_q  <= '0;
			seen_q    <= '0;
		end else if (pop) begin
			if (head.ev.last) begin
				started_q <= '0;
				unique_q  <= '0;
				seen_q    <= '0;
			end else begin
				started_q <= started_next;
				unique_q  <= unique_next;
				if (head.ev.start) begin
					seen_q[head.ev.opcode] <= 1'b1;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.ev.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop && head.ev.last) begin
			result_q <= OUT_DATA_W'({unique_next, started_next});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

endmodule

// ===== src/osp_checker.sv =====
// Port-level checks for the opcode stream profiler, bound to the top level.
// Depends on osp_pkg and opcode_stream_profiler_top.
module osp_checker
	import osp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [OPCODE_W-1:0]   s_tdata,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result transfer keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every buffer starts with an opcode, so a result counts at least one instruction.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] != '0) && (m_tdata[25:17] != '0))
		else $error("empty buffer result");

	// Distinct opcodes never exceed the map size nor the instruction count.
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:17] <= DISTINCT_W'(OPCODE_NUM))
			&& (TOTAL_W'(m_tdata[25:17]) <= m_tdata[16:0]))
		else $error("distinct opcode count out of range");

	// The instruction count respects its cap and padding bits stay clear.
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] <= COUNT_CAP) && (m_tdata[31:26] == '0))
		else $error("instruction count above cap or padding set");

endmodule

bind opcode_stream_profiler_top osp_checker u_osp_checker (.*);

// ===== verif/osp_report_checker.sv =====
`timescale 1ns / 1ps
// Report checker for the opcode stream profiler: watches both stream channels, predicts each
// buffer report from the accepted code bytes and compares it field by field. Uses osp_pkg.
module osp_report_checker
	import osp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [OPCODE_W-1:0]   s_tdata,  // code_byte [7:0]
	input  logic                  s_tlast,  // last_byte
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // instruction_total [16:0], distinct_opcodes [25:17]
	output int                    fail_count,
	output int                    pending,
	output int                    reports_checked
);

	// The instruction count stops at the smaller of the buffer size limit and 65536.
	localparam int TOTAL_CAP = (MAX_CODE_BYTES < 65536) ? MAX_CODE_BYTES : 65536;

	// Length in bytes of every 8051 instruction, indexed by opcode.
	localparam int INSTR_LEN [0:255] = '{
		1,2,3,1,1,2,1,1, 1,1,1,1,1,1,1,1,
		3,2,3,1,1,2,1,1, 1,1,1,1,1,1,1,1,
		3,2,1,1,2,2,1,1, 1,1,1,1,1,1,1,1,
		3,2,1,1,2,2,1,1, 1,1,1,1,1,1,1,1,
		2,2,2,3,2,2,1,1, 1,1,1,1,1,1,1,1,
		2,2,2,3,2,2,1,1, 1,1,1,1,1,1,1,1,
		2,2,2,3,2,2,1,1, 1,1,1,1,1,1,1,1,
		2,2,2,1,2,3,2,2, 2,2,2,2,2,2,2,2,
		2,2,2,1,1,3,2,2, 2,2,2,2,2,2,2,2,
		3,2,2,1,2,2,1,1, 1,1,1,1,1,1,1,1,
		2,2,2,1,1,1,2,2, 2,2,2,2,2,2,2,2,
		2,2,2,1,3,3,3,3, 3,3,3,3,3,3,3,3,
		2,2,2,1,1,2,1,1, 1,1,1,1,1,1,1,1,
		2,2,2,1,1,3,1,1, 2,2,2,2,2,2,2,2,
		1,2,1,1,1,2,1,1, 1,1,1,1,1,1,1,1,
		1,2,1,1,1,2,1,1, 1,1,1,1,1,1,1,1
	};

	typedef struct packed {
		logic [TOTAL_W-1:0]    total;
		logic [DISTINCT_W-1:0] distinct;
	} buffer_report_t;

	buffer_report_t        expected_reports[$];
	logic [1:0]            operands_to_skip;
	logic [TOTAL_W-1:0]    instr_count;
	logic [OPCODE_NUM-1:0] opcode_map;
	logic [DISTINCT_W-1:0] distinct_count;

	// Forget everything about the current buffer.
	task automatic clear_profile();
		operands_to_skip = '0;
		instr_count      = '0;
		opcode_map       = '0;
		distinct_count   = '0;
	endtask

	// Advance the profile by one code byte and queue a report on the last byte of a buffer.
	task automatic profile_byte(input logic [OPCODE_W-1:0] code, input logic last);
		buffer_report_t rep;
		if (operands_to_skip != 0) begin
			operands_to_skip = operands_to_skip - 2'd1;
		end else begin
			if (instr_count < TOTAL_CAP) begin
				instr_count = instr_count + 1'b1;
			end
			if (!opcode_map[code]) begin
				opcode_map[code] = 1'b1;
				distinct_count   = distinct_count + 1'b1;
			end
			operands_to_skip = 2'(INSTR_LEN[code] - 1);
		end
		if (last) begin
			rep.total    = instr_count;
			rep.distinct = distinct_count;
			expected_reports.push_back(rep);
			clear_profile();
		end
	endtask

	// Compare one report taken from the block with the oldest prediction.
	task automatic check_report(input logic [OUT_DATA_W-1:0] data);
		buffer_report_t want;
		logic [TOTAL_W-1:0]    got_total;
		logic [DISTINCT_W-1:0] got_distinct;
		got_total    = data[TOTAL_W-1:0];
		got_distinct = data[TOTAL_W +: DISTINCT_W];
		if (expected_reports.size() == 0) begin
			$error("report with nothing expected: tdata %h", data);
			fail_count++;
		end else begin
			want = expected_reports.pop_front();
			reports_checked++;
			if (got_total !== want.total) begin
				$error("instruction_total: expected %0d, actual %0d", want.total, got_total);
				fail_count++;
			end
			if (got_distinct !== want.distinct) begin
				$error("distinct_opcodes: expected %0d, actual %0d", want.distinct, got_distinct);
				fail_count++;
			end
			if (data[OUT_DATA_W-1:TOTAL_W+DISTINCT_W] !== '0) begin
				$error("tdata padding: expected 0, actual %h",
					data[OUT_DATA_W-1:TOTAL_W+DISTINCT_W]);
				fail_count++;
			end
		end
	endtask

	// Sample both channels at each edge; reports leave before new bytes are profiled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_profile();
			expected_reports.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				check_report(m_tdata);
			end
			if (s_tvalid && s_tready) begin
				profile_byte(s_tdata, s_tlast);
			end
		end
		pending = expected_reports.size();
	end

endmodule

// ===== verif/opcode_stream_profiler_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the opcode stream profiler: clock, reset, code byte stimulus and verdict.
// Depends on osp_pkg, opcode_stream_profiler_top and osp_report_checker.
module opcode_stream_profiler_top_tb;
	import osp_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 16;
	localparam int RANDOM_BYTES  = 530;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OPCODE_W-1:0]   s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int reports_checked;
	int bytes_sent   = 0;
	int buffers_sent = 0;
	int cycles       = 0;
	bit idle_on      = 1'b1;
	bit hold_req     = 1'b0;

	opcode_stream_profiler_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	osp_report_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending         (pending),
		.reports_checked (reports_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Offer one code byte, after an optional idle burst, and wait for its transfer.
	task automatic put_byte(input logic [OPCODE_W-1:0] code, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		if (last) begin
			buffers_sent++;
		end
	endtask

	// Send a buffer of well-formed instructions, optionally cutting the final one short.
	task automatic send_program(input int n_instr, input bit cut);
		logic [OPCODE_W-1:0] prog[$];
		logic [OPCODE_W-1:0] op;
		int tail;
		tail = 0;
		for (int i = 0; i < n_instr; i++) begin
			case ($urandom_range(0, 7))
				0:       op = 8'h02;
				1:       op = 8'h12;
				2:       op = 8'h90;
				3:       op = 8'h85;
				4:       op = 8'hA5;
				default: op = 8'($urandom_range(0, 255));
			endcase
			prog.push_back(op);
			tail = OPERAND_BYTES[op];
			repeat (tail) prog.push_back(8'($urandom_range(0, 255)));
		end
		if (cut && tail > 0) begin
			repeat ($urandom_range(1, tail)) void'(prog.pop_back());
		end
		for (int i = 0; i < prog.size(); i++) begin
			put_byte(prog[i], i == prog.size() - 1);
		end
	endtask

	// Send a buffer of arbitrary bytes.
	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++) begin
			put_byte(8'($urandom_range(0, 255)), i == n - 1);
		end
	endtask

	// Receiver: random short stalls, and one long hold-off when the stimulus asks for it.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 4);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycles < LIMIT_CYCLES) @(posedge clk) cycles++;
		$display("opcode_stream_profiler_top_tb: errors");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int start_bytes;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-byte buffers at both extremes of the code byte.
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b1);
		// A long jump cut off after its first operand byte.
		put_byte(8'h02, 1'b0);
		put_byte(8'h12, 1'b1);
		// A complete long call, then the undefined opcode as the final byte.
		put_byte(8'h12, 1'b0);
		put_byte(8'h34, 1'b0);
		put_byte(8'h56, 1'b0);
		put_byte(8'hA5, 1'b1);
		// The same opcode twice counts once among distinct opcodes.
		put_byte(8'h90, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h90, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		// A direct-to-direct move cut off after one operand byte.
		put_byte(8'h85, 1'b0);
		put_byte(8'h01, 1'b1);
		// Undefined opcode twice, then a two-byte move ending the buffer.
		put_byte(8'hA5, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(8'h7F, 1'b0);
		put_byte(8'hFF, 1'b1);

		// Random buffers, mostly well-formed code with some raw noise and some large ones.
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0:       send_noise($urandom_range(1, 16));
				1:       send_program($urandom_range(20, 60), 1'($urandom_range(0, 1)));
				default: send_program($urandom_range(1, 10), $urandom_range(0, 3) == 0);
			endcase
		end

		// Hold the receiver off while short buffers keep arriving, so the block backs up.
		hold_req = 1'b1;
		for (int i = 0; i < 60; i++) begin
			put_byte(8'($urandom_range(0, 255)), i == 59 || $urandom_range(0, 2) != 0);
		end

		// Final stretch without idling: a few buffers, then every opcode once in one buffer.
		idle_on = 1'b0;
		for (int i = 0; i < 6; i++) begin
			send_program($urandom_range(1, 8), 1'($urandom_range(0, 1)));
		end
		for (int op = 0; op < OPCODE_NUM; op++) begin
			put_byte(8'(op), 1'b0);
			repeat (OPERAND_BYTES[op]) put_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		put_byte(8'h00, 1'b1);
		s_tvalid <= 1'b0;

		// Let every expected report arrive, then watch a little longer for strays.
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d code bytes in %0d buffers and checked %0d reports.",
			bytes_sent, buffers_sent, reports_checked);
		$display("Included cut-off instructions, a long output hold-off and a full opcode sweep.");
		if (fail_count == 0 && pending == 0) begin
			$display("opcode_stream_profiler_top_tb: clean");
		end else begin
			$display("opcode_stream_profiler_top_tb: errors");
		end
		$finish;
	end

endmodule
